// ===== hdl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

    // word widths and key size
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = 2;

    // round constant added to the running sum once per round
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    // operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [KEY_WORDS-1:0] t_key_set;

    // one block traveling down the round pipeline
    typedef struct packed {
        logic  valid;
        logic  op;
        t_word first;
        t_word second;
    } t_stage;

    // finished block on its way to the output
    typedef struct packed {
        t_word first;
        t_word second;
    } t_res;

endpackage : xtea_pkg

`default_nettype wire

// ===== hdl/xtea_in_if.sv =====
`default_nettype none

interface xtea_in_if;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [xtea_pkg::WORD_W-1:0] block_first;
    logic [xtea_pkg::WORD_W-1:0] block_second;

    modport source (output valid, output operation, output block_first,
                    output block_second, input ready);
    modport sink   (input valid, input operation, input block_first,
                    input block_second, output ready);

endinterface : xtea_in_if

`default_nettype wire

// ===== hdl/xtea_out_if.sv =====
`default_nettype none

interface xtea_out_if;

    logic                       valid;
    logic                       ready;
    logic [xtea_pkg::WORD_W-1:0] out_first;
    logic [xtea_pkg::WORD_W-1:0] out_second;

    modport source (output valid, output out_first, output out_second, input ready);
    modport sink   (input valid, input out_first, input out_second, output ready);

endinterface : xtea_out_if

`default_nettype wire

// ===== hdl/xtea_block_cipher.sv =====
// XTEA block cipher, 64-bit block, 128-bit key, fully pipelined.
// Input channel i_in_ch carries operation (0 encrypt, 1 decrypt) and the
// block as block_first / block_second; output channel o_out_ch returns the
// result block as out_first / out_second, one result word per input word,
// in order.
// The key is four 32-bit words written through i_cfg_we / i_cfg_index /
// i_cfg_data, one word per write; change it only while no block is in flight.
// Each round is two half-round stages, one register each, so the pipeline is
// 2*ROUNDS stages deep followed by an output register with one spare slot.
// Throughput is one block per cycle as long as the receiver keeps taking
// results.
// Reset clears all valid bits and the key words to zero.
// When the receiver stalls, the output holds its word, the spare slot takes
// one more, then i_in_ch.ready drops and the whole pipeline freezes in place
// until the output drains; nothing is lost or repeated.
`default_nettype none

module xtea_block_cipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [xtea_pkg::KEY_IDX_W-1:0] i_cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]  i_cfg_data,
    xtea_in_if.sink                           i_in_ch,
    xtea_out_if.source                        o_out_ch
);
    import xtea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;

    t_key_set r_key;
    t_stage   w_stage [STAGES+1];
    logic     pipe_en;
    t_res     last_res;

    // key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // input word enters the first stage
    assign i_in_ch.ready = pipe_en;
    assign w_stage[0]    = '{valid:  i_in_ch.valid,
                             op:     i_in_ch.operation,
                             first:  i_in_ch.block_first,
                             second: i_in_ch.block_second};

    // round stages with their sums fixed at elaboration
    for (genvar g = 0; g < STAGES; g++) begin : g_half
        localparam int unsigned RND    = g / 2;
        localparam bit          HB     = (g % 2) == 1;
        localparam int unsigned ENC_K  = HB ? RND + 1 : RND;
        localparam int unsigned DEC_K  = HB ? ROUNDS - RND - 1 : ROUNDS - RND;
        localparam logic [63:0] ENC_P  = 64'(XTEA_DELTA) * 64'(ENC_K);
        localparam logic [63:0] DEC_P  = 64'(XTEA_DELTA) * 64'(DEC_K);

        xtea_half #(
            .SUM_ENC (ENC_P[31:0]),
            .SUM_DEC (DEC_P[31:0]),
            .HALF    (HB)
        ) u_half (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_key   (r_key),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // output register with spare slot
    assign last_res = '{first: w_stage[STAGES].first, second: w_stage[STAGES].second};

    xtea_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_stage[STAGES].valid),
        .i_res    (last_res),
        .o_ready  (pipe_en),
        .o_out_ch (o_out_ch)
    );

endmodule : xtea_block_cipher

`default_nettype wire

// ===== hdl/xtea_half.sv =====
`default_nettype none

module xtea_half #(
    parameter logic [31:0] SUM_ENC = 32'h0,
    parameter logic [31:0] SUM_DEC = 32'h0,
    parameter bit          HALF    = 1'b0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire xtea_pkg::t_key_set i_key,
    input  wire xtea_pkg::t_stage   i_stage,
    output xtea_pkg::t_stage        o_stage
);
    import xtea_pkg::*;

    // key word picked by the sum: low bits on one half, bits 12:11 on the other
    localparam logic [KEY_IDX_W-1:0] KI_ENC = HALF ? SUM_ENC[12:11] : SUM_ENC[1:0];
    localparam logic [KEY_IDX_W-1:0] KI_DEC = HALF ? SUM_DEC[1:0]   : SUM_DEC[12:11];

    logic  upd_first;
    logic  is_dec;
    t_word src;
    t_word tgt;
    t_word sum;
    t_word kw;
    t_word mix;
    t_word res;
    t_word n_first;
    t_word n_second;

    logic  r_valid;
    logic  r_op;
    t_word r_first;
    t_word r_second;

    // half round: encrypt adds into one word, decrypt undoes it in reverse order
    always_comb begin
        is_dec    = (i_stage.op == OP_DECRYPT);
        upd_first = (i_stage.op == HALF);
        src       = upd_first ? i_stage.second : i_stage.first;
        tgt       = upd_first ? i_stage.first  : i_stage.second;
        sum       = is_dec ? SUM_DEC : SUM_ENC;
        kw        = is_dec ? i_key[KI_DEC] : i_key[KI_ENC];
        mix       = (((src << 4) ^ (src >> 5)) + src) ^ (sum + kw);
        res       = is_dec ? (tgt - mix) : (tgt + mix);
        n_first   = upd_first ? res : i_stage.first;
        n_second  = upd_first ? i_stage.second : res;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op     <= i_stage.op;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_stage = '{valid: r_valid, op: r_op, first: r_first, second: r_second};

endmodule : xtea_half

`default_nettype wire

// ===== hdl/xtea_skid.sv =====
`default_nettype none

module xtea_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire xtea_pkg::t_res i_res,
    output logic                o_ready,
    xtea_out_if.source          o_out_ch
);
    import xtea_pkg::*;

    logic r_out_valid;
    t_res r_out_res;
    logic r_skid_valid;
    t_res r_skid_res;
    logic out_free;

    assign out_free = o_out_ch.ready || !r_out_valid;
    assign o_ready  = !r_skid_valid;

    // output register and one spare slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_res <= r_skid_valid ? r_skid_res : i_res;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_res <= i_res;
        end
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.out_first  = r_out_res.first;
    assign o_out_ch.out_second = r_out_res.second;

endmodule : xtea_skid

`default_nettype wire
